// ===== hdl/twkf_pkg.sv =====
// twkf_pkg: shared widths, register indexes and types of the windowed top-k coefficient filter
// no dependencies; imported by twkf_cell, the top level, the checker and the testbench
package twkf_pkg;

  localparam int COEFF_W   = 24;
  localparam int RANK_W    = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int USER_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 2'd1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd64;
  localparam logic [CFG_W-1:0] KEEP_COUNT_RST  = 7'd8;

  // bit positions inside out_tuser
  localparam int USER_KEPT      = 0;
  localparam int USER_DATA_LAST = 1;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                      ld;    // a coefficient is being loaded
    logic                      sh;    // the row shifts one place toward the head
    logic signed [COEFF_W-1:0] bval;  // loaded coefficient, or the head value on a shift
  } cell_ctl_t;

endpackage

// ===== hdl/windowed_top_k_coefficient_filter.sv =====
// windowed_top_k_coefficient_filter: top level, control, configuration and output register
// depends on twkf_pkg and twkf_cell
//
// Buffers signed 24-bit coefficients into a row of MAX_WINDOW cells until the window
// (window_size, 0 read as 1, above MAX_WINDOW read as MAX_WINDOW) is full or a beat with
// in_tlast (end of data) arrives, then emits every buffered coefficient in arrival order.
// A coefficient passes unchanged with kept set if its rank in the window is at most
// keep_count, otherwise it leaves as zero with kept clear; rank 1 is the largest value
// and among equal values the later one ranks higher. Each cell keeps a running rank:
// a loaded coefficient is compared with every cell at once, and while emitting the head
// value is compared with the cells behind it as the row shifts toward the head.
// Rate: one coefficient per cycle is loaded, and one per cycle is emitted while the sink
// does not stall; input is not taken while a window drains, since the single head cell
// is the only read port.
// Configuration is taken in any cycle (cfg_ready is tied high) and should only be
// written while the block is idle.
module windowed_top_k_coefficient_filter #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [twkf_pkg::COEFF_W-1:0]        in_tdata,   // [23:0] coeff
  input  logic                                in_tlast,   // end_of_data
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [twkf_pkg::COEFF_W-1:0]        out_tdata,  // [23:0] coeff_out
  output logic                                out_tlast,  // window_last
  output logic [twkf_pkg::USER_W-1:0]         out_tuser,  // [0] kept, [1] data_last
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [twkf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twkf_pkg::CFG_W-1:0]          cfg_data
);
  import twkf_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);  // fill count, holds MAX_WINDOW itself
  localparam int IW = $clog2(MAX_WINDOW);      // cell index

  // configuration registers
  logic [CFG_W-1:0] win_size_r, win_size_nxt;
  logic [CFG_W-1:0] keep_r, keep_nxt;

  // control
  state_t           state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;       // buffered count, then remaining while emitting
  logic             eod_r, eod_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [COEFF_W-1:0]        out_coeff_r, out_coeff_nxt;
  logic                      out_kept_r, out_kept_nxt;
  logic                      out_wlast_r, out_wlast_nxt;
  logic                      out_dlast_r, out_dlast_nxt;

  logic                      in_fire;
  logic                      emit_fire;
  logic                      flush;
  logic [CW-1:0]             fill_inc;
  logic [CFG_W-1:0]          eff_size;
  logic                      head_kept;
  logic                      head_last;
  cell_ctl_t                 ctl;

  // row of cells
  logic signed [COEFF_W-1:0] cell_val  [MAX_WINDOW];
  logic [RANK_W-1:0]         cell_rank [MAX_WINDOW];
  logic [RANK_W-1:0]         cell_shr  [MAX_WINDOW];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // window size clamped to 1..MAX_WINDOW
  always_comb begin
    if (win_size_r == '0) begin
      eff_size = {{(CFG_W-1){1'b0}}, 1'b1};
    end else if (win_size_r > CFG_W'(MAX_WINDOW)) begin
      eff_size = CFG_W'(MAX_WINDOW);
    end else begin
      eff_size = win_size_r;
    end
  end

  assign fill_inc  = fill_r + {{(CW-1){1'b0}}, 1'b1};
  assign flush     = in_tlast || (CFG_W'(fill_inc) >= eff_size);

  // head of the row decides kept; last beat of the window when one is left
  assign head_kept = (cell_rank[0] <= keep_r);
  assign head_last = (fill_r == {{(CW-1){1'b0}}, 1'b1});

  // broadcast: the incoming coefficient on a load, the head value on a shift
  assign ctl.ld   = in_fire;
  assign ctl.sh   = emit_fire;
  assign ctl.bval = in_fire ? $signed(in_tdata) : cell_val[0];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic                      we;
    logic signed [COEFF_W-1:0] nb_val;
    logic [RANK_W-1:0]         nb_rank;

    assign we = in_fire && (fill_r[IW-1:0] == IW'(k));

    if (k < MAX_WINDOW - 1) begin : g_mid
      assign nb_val  = cell_val[k+1];
      assign nb_rank = cell_shr[k+1];
    end else begin : g_end
      assign nb_val  = '0;
      assign nb_rank = '0;
    end

    twkf_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .we        (we),
      .nb_val    (nb_val),
      .nb_rank   (nb_rank),
      .val_o     (cell_val[k]),
      .rank_o    (cell_rank[k]),
      .sh_rank_o (cell_shr[k])
    );
  end

  // configuration
  always_comb begin
    win_size_nxt = win_size_r;
    keep_nxt     = keep_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_SIZE: win_size_nxt = cfg_data;
        REG_KEEP_COUNT:  keep_nxt     = cfg_data;
        default:         ;  // writes past the register list are dropped
      endcase
    end
  end

  // load / emit sequencing
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    eod_nxt   = eod_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          fill_nxt = fill_inc;
          if (flush) begin
            eod_nxt   = in_tlast;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          fill_nxt = fill_r - {{(CW-1){1'b0}}, 1'b1};
          if (head_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
        fill_nxt  = '0;
      end
    endcase
  end

  // output register, refilled while the sink takes the previous beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_coeff_nxt = out_coeff_r;
    out_kept_nxt  = out_kept_r;
    out_wlast_nxt = out_wlast_r;
    out_dlast_nxt = out_dlast_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_coeff_nxt = head_kept ? cell_val[0] : '0;
      out_kept_nxt  = head_kept;
      out_wlast_nxt = head_last;
      out_dlast_nxt = head_last && eod_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      eod_r       <= 1'b0;
      out_valid_r <= 1'b0;
      win_size_r  <= WINDOW_SIZE_RST;
      keep_r      <= KEEP_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      eod_r       <= eod_nxt;
      out_valid_r <= out_valid_nxt;
      win_size_r  <= win_size_nxt;
      keep_r      <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_coeff_r <= out_coeff_nxt;
    out_kept_r  <= out_kept_nxt;
    out_wlast_r <= out_wlast_nxt;
    out_dlast_r <= out_dlast_nxt;
  end

  assign out_tvalid                = out_valid_r;
  assign out_tdata                 = out_coeff_r;
  assign out_tlast                 = out_wlast_r;
  assign out_tuser[USER_KEPT]      = out_kept_r;
  assign out_tuser[USER_DATA_LAST] = out_dlast_r;

endmodule

// ===== hdl/twkf_cell.sv =====
// twkf_cell: one cell of the ranking row, holds one coefficient and its running rank
// depends on twkf_pkg
module twkf_cell (
  input  logic                               clk,
  input  twkf_pkg::cell_ctl_t                ctl,
  input  logic                               we,
  input  logic signed [twkf_pkg::COEFF_W-1:0] nb_val,
  input  logic [twkf_pkg::RANK_W-1:0]        nb_rank,
  output logic signed [twkf_pkg::COEFF_W-1:0] val_o,
  output logic [twkf_pkg::RANK_W-1:0]        rank_o,
  output logic [twkf_pkg::RANK_W-1:0]        sh_rank_o
);
  import twkf_pkg::*;

  logic signed [COEFF_W-1:0] val_r, val_nxt;
  logic [RANK_W-1:0]         rank_r, rank_nxt;
  logic                      ld_hit;
  logic                      sh_hit;

  // a later entry that is greater or equal pushes this one down
  assign ld_hit = (ctl.bval >= val_r);
  // an earlier entry that is strictly greater pushes this one down
  assign sh_hit = (val_r < ctl.bval);

  assign sh_rank_o = rank_r + {{(RANK_W-1){1'b0}}, sh_hit};

  always_comb begin
    val_nxt  = val_r;
    rank_nxt = rank_r;
    if (we) begin
      val_nxt  = ctl.bval;
      rank_nxt = {{(RANK_W-1){1'b0}}, 1'b1};
    end else if (ctl.ld) begin
      rank_nxt = rank_r + {{(RANK_W-1){1'b0}}, ld_hit};
    end else if (ctl.sh) begin
      val_nxt  = nb_val;
      rank_nxt = nb_rank;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rank_r <= rank_nxt;
  end

  assign val_o  = val_r;
  assign rank_o = rank_r;

endmodule

// ===== hdl/twkf_checker.sv =====
// twkf_checker: port-level checks of the windowed top-k coefficient filter, bound to the top
// depends on twkf_pkg and windowed_top_k_coefficient_filter
module twkf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [twkf_pkg::COEFF_W-1:0]   out_tdata,
  input logic                           out_tlast,
  input logic [twkf_pkg::USER_W-1:0]    out_tuser
);
  import twkf_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // an end-of-data beat always flushes, so input closes right after it
  a_eod_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still open after end of data");

  // end of data only marks the last beat of a window
  a_dlast_wlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_DATA_LAST] |-> out_tlast)
    else $error("data_last without window_last");

  // a dropped coefficient leaves as zero
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_KEPT] |-> out_tdata == '0)
    else $error("dropped coefficient not zero");

endmodule

bind windowed_top_k_coefficient_filter twkf_checker u_twkf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== verif/tb.sv =====
// tb: self-checking testbench for windowed_top_k_coefficient_filter
// depends on twkf_pkg and the filter top level; predicts every filtered beat and checks it
// a directed script comes first, then random window-sized bursts under random stalls
module tb;
  import twkf_pkg::*;

  localparam int MAX_WIN          = 64;
  localparam int SETTLE_CYCLES    = 20;
  localparam int TAIL_CYCLES      = 40;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_ITEMS     = 380;
  localparam int SHOWN_MISMATCHES = 10;

  // indexes outside the register map, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic               kept;
    logic               wlast;
    logic               dlast;
  } filt_out_t;

  typedef struct {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]   val;
    logic [COEFF_W-1:0] coeff;
    logic               eod;
    bit                 typed;
    filt_out_t          want;
  } step_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [COEFF_W-1:0]   in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  logic [COEFF_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic [USER_W-1:0]    out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  windowed_top_k_coefficient_filter #(.MAX_WINDOW(MAX_WIN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: buffered window and register copies
  logic signed [COEFF_W-1:0] win_buf [MAX_WIN];
  int                        win_fill     = 0;
  logic [CFG_W-1:0]          win_size_reg = WINDOW_SIZE_RST;
  logic [CFG_W-1:0]          keep_reg     = KEEP_COUNT_RST;

  filt_out_t flush_q[$];   // beats of the flush caused by the latest coefficient
  filt_out_t due_q[$];     // filtered beats still awaited from the block
  step_row_t script[$];

  bit        calm = 1'b0;  // no idling on either side while set
  int        n_errors = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  int        draw;
  filt_out_t got_res;
  filt_out_t due_res;

  function automatic int eff_window();
    if (win_size_reg == 0) return 1;
    if (win_size_reg > MAX_WIN) return MAX_WIN;
    return int'(win_size_reg);
  endfunction

  // buffer one coefficient, and on a flush rank the window and fill flush_q
  function automatic void filter_step(logic [COEFF_W-1:0] c, logic eod);
    int        n;
    int        rank;
    filt_out_t res;
    flush_q.delete();
    if (win_fill < MAX_WIN) begin
      win_buf[win_fill] = c;
      win_fill++;
    end
    if (!eod && win_fill < eff_window()) return;
    n = win_fill;
    for (int i = 0; i < n; i++) begin
      rank = 1;
      // larger values, and equal values further back, rank ahead
      for (int j = 0; j < n; j++)
        if (win_buf[j] > win_buf[i] || (win_buf[j] == win_buf[i] && j > i)) rank++;
      res.kept  = (rank <= keep_reg);
      res.coeff = res.kept ? win_buf[i] : '0;
      res.wlast = (i == n - 1);
      res.dlast = (i == n - 1) && eod;
      flush_q.push_back(res);
    end
    win_fill = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == REG_WINDOW_SIZE) win_size_reg = val;
    else if (idx == REG_KEEP_COUNT) keep_reg = val;
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
      3, 4:    return COEFF_W'($urandom_range(0, 4)) - 24'd2;  // small values, many ties
      default: return COEFF_W'($urandom());
    endcase
  endfunction

  function automatic void dir_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_row_t row;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.val   = val;
    row.coeff = '0;
    row.eod   = 1'b0;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  function automatic void dir_item(logic [COEFF_W-1:0] c, logic eod);
    step_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.val   = '0;
    row.coeff = c;
    row.eod   = eod;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  // item whose single result is known by inspection
  function automatic void dir_typed(logic [COEFF_W-1:0] c, logic eod,
                                    logic [COEFF_W-1:0] ec, logic ek, logic ew, logic ed);
    dir_item(c, eod);
    script[$].typed = 1'b1;
    script[$].want  = '{coeff: ec, kept: ek, wlast: ew, dlast: ed};
  endfunction

  task automatic send_coeff(logic [COEFF_W-1:0] c, logic eod, bit typed, filt_out_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    filter_step(c, eod);
    if (typed) due_q.push_back(want);
    else foreach (flush_q[k]) due_q.push_back(flush_q[k]);
  endtask

  // valid stays high when another register beat follows
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // stop input, let every awaited beat arrive, then let a trailing load settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] ws, logic [CFG_W-1:0] kc, bit spare);
    quiesce();
    cfg_write(REG_WINDOW_SIZE, ws, 1'b1);
    cfg_write(REG_KEEP_COUNT, kc, spare);
    if (spare)
      cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom()), 1'b0);
  endtask

  // result side: check every accepted beat, then stall for a random count
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_res.coeff = out_tdata;
        got_res.kept  = out_tuser[USER_KEPT];
        got_res.wlast = out_tlast;
        got_res.dlast = out_tuser[USER_DATA_LAST];
        if (due_q.size() == 0) begin
          if (n_errors < SHOWN_MISMATCHES)
            $display("unexpected beat: coeff %h kept %b wlast %b dlast %b",
                     got_res.coeff, got_res.kept, got_res.wlast, got_res.dlast);
          n_errors++;
        end else begin
          due_res = due_q.pop_front();
          if (got_res !== due_res) begin
            if (n_errors < SHOWN_MISMATCHES)
              $display("mismatch: want %h/%b/%b/%b got %h/%b/%b/%b (coeff/kept/wlast/dlast)",
                       due_res.coeff, due_res.kept, due_res.wlast, due_res.dlast,
                       got_res.coeff, got_res.kept, got_res.wlast, got_res.dlast);
            n_errors++;
          end
        end
        draw = calm ? 0 : $urandom_range(0, 15);
        stall_left <= draw;
        out_tready <= (draw == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= (stall_left == 1);
      end
    end
  end

  // cycles without any accepted beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int               rand_items;
    int               eff;
    int               n_win;
    int               tail;
    int               len;
    logic [CFG_W-1:0] ws;
    logic [CFG_W-1:0] kc;
    logic             eod;
    rand_items = 0;

    // single item flushed by end of data at reset settings
    dir_typed(24'h000005, 1'b1, 24'h000005, 1'b1, 1'b1, 1'b1);
    // one-coefficient windows, extremes pass through
    dir_cfg(REG_WINDOW_SIZE, 7'd1);
    dir_cfg(REG_KEEP_COUNT, 7'd1);
    dir_typed(24'h7FFFFF, 1'b0, 24'h7FFFFF, 1'b1, 1'b1, 1'b0);
    dir_typed(24'h800000, 1'b0, 24'h800000, 1'b1, 1'b1, 1'b0);
    dir_typed(24'h000000, 1'b1, 24'h000000, 1'b1, 1'b1, 1'b1);
    // keep count zero zeroes everything
    dir_cfg(REG_KEEP_COUNT, 7'd0);
    dir_typed(24'h123456, 1'b0, 24'h000000, 1'b0, 1'b1, 1'b0);
    // window size zero reads as one
    dir_cfg(REG_WINDOW_SIZE, 7'd0);
    dir_cfg(REG_KEEP_COUNT, 7'd64);
    dir_typed(24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    // ties: the later of two equal values ranks higher
    dir_cfg(REG_WINDOW_SIZE, 7'd4);
    dir_cfg(REG_KEEP_COUNT, 7'd2);
    dir_item(24'h000003, 1'b0);
    dir_item(24'hFFFFFE, 1'b0);
    dir_item(24'h000003, 1'b0);
    dir_item(24'h7FFFFF, 1'b0);
    // oversized window saturates, keep count above the fill keeps all
    dir_cfg(REG_WINDOW_SIZE, 7'd127);
    dir_cfg(REG_KEEP_COUNT, 7'd127);
    dir_item(24'h800000, 1'b0);
    dir_item(24'h555555, 1'b0);
    dir_item(24'hAAAAAA, 1'b1);
    // partial window left open, then the size drops below the fill
    dir_cfg(REG_WINDOW_SIZE, 7'd8);
    dir_cfg(REG_KEEP_COUNT, 7'd3);
    dir_item(24'h000010, 1'b0);
    dir_item(24'h000010, 1'b0);
    dir_item(24'h000010, 1'b0);
    dir_item(24'h000010, 1'b0);
    dir_item(24'h7FFFFF, 1'b0);
    dir_cfg(REG_WINDOW_SIZE, 7'd3);
    dir_cfg(REG_KEEP_COUNT, 7'd2);
    dir_item(24'h00000F, 1'b0);
    // writes outside the register map change nothing
    dir_cfg(REG_SPARE_A, 7'h55);
    dir_cfg(REG_SPARE_B, 7'h2A);
    dir_item(24'h400000, 1'b0);
    dir_item(24'hC00000, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        if (r == 0 || script[r-1].kind != ROW_CFG) quiesce();
        cfg_write(script[r].idx, script[r].val,
                  r + 1 < script.size() && script[r+1].kind == ROW_CFG);
      end else begin
        send_coeff(script[r].coeff, script[r].eod, script[r].typed, script[r].want);
      end
    end

    // random phases: new settings, whole windows, then a tail that may stay open
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       ws = 7'd0;
        1:       ws = 7'd1;
        2:       ws = 7'd64;
        3:       ws = CFG_W'($urandom_range(65, 127));
        default: ws = CFG_W'($urandom_range(2, 12));
      endcase
      eff = (ws == 0) ? 1 : (ws > MAX_WIN) ? MAX_WIN : int'(ws);
      case ($urandom_range(0, 7))
        0:       kc = 7'd0;
        1:       kc = CFG_W'($urandom_range(64, 127));
        2:       kc = 7'd1;
        3:       kc = CFG_W'(eff);
        default: kc = CFG_W'($urandom_range(0, eff));
      endcase
      set_regs(ws, kc, $urandom_range(0, 3) == 0);
      calm  = ($urandom_range(0, 4) == 0);
      n_win = (eff > 16) ? 1 : $urandom_range(1, 3);
      for (int w = 0; w < n_win; w++) begin
        for (int p = 0; p < eff; p++) begin
          // stray end of data now and then breaks the window early
          eod = (w == n_win - 1 && p == eff - 1 && $urandom_range(0, 1) == 1) ||
                $urandom_range(0, 31) == 0;
          send_coeff(rand_coeff(), eod, 1'b0, '0);
          rand_items++;
        end
      end
      tail = $urandom_range(0, 2);
      if (tail != 0) begin
        len = $urandom_range(1, eff);
        for (int p = 0; p < len; p++) begin
          eod = (tail == 1) && (p == len - 1);
          send_coeff(rand_coeff(), eod, 1'b0, '0);
          rand_items++;
        end
      end
    end

    calm = 1'b0;
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ===== windowed_top_k_coefficient_filter.f =====
hdl/twkf_pkg.sv
hdl/twkf_cell.sv
hdl/windowed_top_k_coefficient_filter.sv
hdl/twkf_checker.sv
verif/tb.sv
